@@ design/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// Delimiter stream splitter package
// Shared widths, result kind codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package dss_pkg;

   localparam int BYTE_W      = 8;
   localparam int SEG_W       = 16;
   localparam int CNT_OUT_W   = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int LEN_W       = 4;

   localparam int DEF_MAX_DELIM_LEN = 8;
   localparam int DEF_COUNT_WIDTH   = 32;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_CONTENT     = 3'd0;
   localparam kind_type KIND_NAME        = 3'd1;
   localparam kind_type KIND_SEGMENT_END = 3'd2;
   localparam kind_type KIND_STREAM_END  = 3'd3;
   localparam kind_type KIND_ERROR       = 3'd4;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_DELIM_WORD = 2'd0;
   localparam csr_index_type CSR_DELIM_LEN  = 2'd1;
   localparam csr_index_type CSR_SELECT     = 2'd2;

endpackage

@@ design/delimiter_stream_splitter.sv @@
// ----------------------------------------------------------------------------
// Delimiter stream splitter
// Splits a byte stream into named segments separated by a programmable
// delimiter and reports names, selected content and segment byte counts.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one byte or an end mark per transaction. The rsp_
//   channel returns zero or more results per request; rsp_last marks the final
//   one. The csr_ channel writes the delimiter word, its length and the
//   selected segment; csr_ready is always high and writes are expected only
//   while the block is idle.
//   A result caused directly by a byte is registered and appears in the cycle
//   after the request is taken. A byte that breaks a partial match, and every
//   end mark in content phase, runs a small sequencer that emits one held
//   delimiter byte per cycle while the output register is free, through the
//   shared saturating byte counter, so such a request occupies the block until
//   its held delimiter bytes and its tail results are out. Others do not.
//   req_stall is high while the sequencer runs and while a result waits in
//   the output register under rsp_stall; a stalled result holds its value.
//   Reset is synchronous: it drops any pending result, returns to name phase
//   with segment index and byte count cleared, and restores the registers
//   (delimiter length 1, all else 0).
// ----------------------------------------------------------------------------
module delimiter_stream_splitter #(
   parameter int MAX_DELIM_LEN = dss_pkg::DEF_MAX_DELIM_LEN,
   parameter int COUNT_WIDTH   = dss_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dss_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                req_end_of_input,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dss_pkg::kind_type                   rsp_kind,
   output logic [dss_pkg::BYTE_W-1:0]          rsp_value,
   output logic [dss_pkg::SEG_W-1:0]           rsp_segment_number,
   output logic [dss_pkg::CNT_OUT_W-1:0]       rsp_byte_count,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  dss_pkg::csr_index_type              csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dss_pkg::*;

   localparam int POS_W = $clog2(MAX_DELIM_LEN + 1);

   localparam logic [1:0] ST_IDLE       = 2'd0;
   localparam logic [1:0] ST_FLUSH      = 2'd1;
   localparam logic [1:0] ST_TAIL       = 2'd2;
   localparam logic [1:0] ST_STREAM_END = 2'd3;

   localparam logic PHASE_NAME    = 1'b0;
   localparam logic PHASE_CONTENT = 1'b1;

   function automatic logic [BYTE_W-1:0] delim_byte(input logic [CSR_DATA_W-1:0] word,
                                                    input logic [2:0] idx);
      delim_byte = word[idx*BYTE_W +: BYTE_W];
   endfunction

   // Control and configuration state.
   logic [1:0]             state_ff, state_in;
   logic                   phase_ff, phase_in;
   logic [POS_W-1:0]       match_pos_ff, match_pos_in;
   logic [POS_W-1:0]       flush_idx_ff, flush_idx_in;
   logic [SEG_W-1:0]       seg_index_ff, seg_index_in;
   logic [COUNT_WIDTH-1:0] seg_bytes_ff, seg_bytes_in;
   logic [CSR_DATA_W-1:0]  delim_word_ff;
   logic [LEN_W-1:0]       delim_len_ff;
   logic [SEG_W-1:0]       select_ff;

   // Request held while the sequencer runs.
   logic [BYTE_W-1:0]      hold_byte_ff, hold_byte_in;
   logic                   hold_eoi_ff, hold_eoi_in;

   // Output register.
   logic                   rsp_valid_ff;
   kind_type               rsp_kind_ff;
   logic [BYTE_W-1:0]      rsp_value_ff;
   logic [SEG_W-1:0]       rsp_seg_ff;
   logic [CNT_OUT_W-1:0]   rsp_count_ff;
   logic                   rsp_last_ff;

   logic                   emit;
   kind_type               e_kind;
   logic [BYTE_W-1:0]      e_value;
   logic [SEG_W-1:0]       e_seg;
   logic [CNT_OUT_W-1:0]   e_count;
   logic                   e_last;

   logic                   out_free;
   logic                   accept;
   logic                   selected;
   logic                   mismatch;
   logic [LEN_W-1:0]       eff_len;
   logic [LEN_W-1:0]       pos_next;
   logic [SEG_W-1:0]       seg_next;
   logic [COUNT_WIDTH-1:0] bytes_inc;
   logic [63:0]            bytes_wide;
   logic [CNT_OUT_W-1:0]   bytes_out;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign selected = (select_ff == '0) || (select_ff == seg_index_ff);
   assign seg_next = (seg_index_ff == '1) ? seg_index_ff : seg_index_ff + 1'b1;

   // Shared saturating counter step for every content byte.
   assign bytes_inc  = (seg_bytes_ff == '1) ? seg_bytes_ff : seg_bytes_ff + 1'b1;
   assign bytes_wide = 64'(seg_bytes_ff);
   assign bytes_out  = (bytes_wide > 64'({CNT_OUT_W{1'b1}})) ? '1 : bytes_wide[CNT_OUT_W-1:0];

   always_comb begin
      if (delim_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (delim_len_ff > LEN_W'(MAX_DELIM_LEN)) begin
         eff_len = LEN_W'(MAX_DELIM_LEN);
      end else begin
         eff_len = delim_len_ff;
      end
   end

   assign pos_next = LEN_W'(match_pos_ff) + 1'b1;
   assign mismatch = (LEN_W'(match_pos_ff) >= LEN_W'(MAX_DELIM_LEN))
                  || (req_data_byte != delim_byte(delim_word_ff, 3'(match_pos_ff)));

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      match_pos_in = match_pos_ff;
      flush_idx_in = flush_idx_ff;
      seg_index_in = seg_index_ff;
      seg_bytes_in = seg_bytes_ff;
      hold_byte_in = hold_byte_ff;
      hold_eoi_in  = hold_eoi_ff;
      emit         = 1'b0;
      e_kind       = KIND_CONTENT;
      e_value      = '0;
      e_seg        = seg_index_ff;
      e_count      = '0;
      e_last       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (phase_ff == PHASE_NAME) begin
                  if (req_end_of_input) begin
                     emit         = 1'b1;
                     e_kind       = KIND_ERROR;
                     e_last       = 1'b1;
                     phase_in     = PHASE_NAME;
                     match_pos_in = '0;
                     seg_index_in = '0;
                     seg_bytes_in = '0;
                  end else if (req_data_byte == NEWLINE_BYTE) begin
                     seg_index_in = seg_next;
                     seg_bytes_in = '0;
                     match_pos_in = '0;
                     phase_in     = PHASE_CONTENT;
                  end else begin
                     emit    = 1'b1;
                     e_kind  = KIND_NAME;
                     e_value = req_data_byte;
                     e_seg   = seg_next;
                     e_last  = 1'b1;
                  end
               end else if (req_end_of_input || (mismatch && match_pos_ff != '0)) begin
                  // Held delimiter bytes go out one per cycle, while the output is free, before the tail.
                  hold_byte_in = req_data_byte;
                  hold_eoi_in  = req_end_of_input;
                  flush_idx_in = '0;
                  state_in     = ST_FLUSH;
               end else if (mismatch) begin
                  emit         = selected;
                  e_value      = req_data_byte;
                  e_last       = 1'b1;
                  seg_bytes_in = bytes_inc;
               end else if (pos_next >= eff_len) begin
                  emit         = 1'b1;
                  e_kind       = KIND_SEGMENT_END;
                  e_count      = bytes_out;
                  e_last       = 1'b1;
                  match_pos_in = '0;
                  phase_in     = PHASE_NAME;
               end else begin
                  match_pos_in = POS_W'(pos_next);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               if (flush_idx_ff == match_pos_ff) begin
                  match_pos_in = '0;
                  state_in     = ST_TAIL;
               end else begin
                  emit         = selected;
                  e_value      = delim_byte(delim_word_ff, 3'(flush_idx_ff));
                  seg_bytes_in = bytes_inc;
                  flush_idx_in = flush_idx_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               if (hold_eoi_ff) begin
                  emit     = 1'b1;
                  e_kind   = KIND_SEGMENT_END;
                  e_count  = bytes_out;
                  state_in = ST_STREAM_END;
               end else begin
                  emit         = selected;
                  e_value      = hold_byte_ff;
                  e_last       = 1'b1;
                  seg_bytes_in = bytes_inc;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_STREAM_END: begin
            if (out_free) begin
               emit         = 1'b1;
               e_kind       = KIND_STREAM_END;
               e_last       = 1'b1;
               phase_in     = PHASE_NAME;
               match_pos_in = '0;
               seg_index_in = '0;
               seg_bytes_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PHASE_NAME;
         match_pos_ff  <= '0;
         flush_idx_ff  <= '0;
         seg_index_ff  <= '0;
         seg_bytes_ff  <= '0;
         delim_word_ff <= '0;
         delim_len_ff  <= LEN_W'(1);
         select_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         match_pos_ff <= match_pos_in;
         flush_idx_ff <= flush_idx_in;
         seg_index_ff <= seg_index_in;
         seg_bytes_ff <= seg_bytes_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DELIM_WORD: delim_word_ff <= csr_data;
               CSR_DELIM_LEN:  delim_len_ff  <= csr_data[LEN_W-1:0];
               CSR_SELECT:     select_ff     <= csr_data[SEG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      hold_eoi_ff  <= hold_eoi_in;
      if (out_free && emit) begin
         rsp_kind_ff  <= e_kind;
         rsp_value_ff <= e_value;
         rsp_seg_ff   <= e_seg;
         rsp_count_ff <= e_count;
         rsp_last_ff  <= e_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_segment_number = rsp_seg_ff;
   assign rsp_byte_count     = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

@@ design/dss_checker.sv @@
// ----------------------------------------------------------------------------
// Delimiter stream splitter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input dss_pkg::kind_type              rsp_kind,
   input logic [dss_pkg::BYTE_W-1:0]     rsp_value,
   input logic [dss_pkg::SEG_W-1:0]      rsp_segment_number,
   input logic [dss_pkg::CNT_OUT_W-1:0]  rsp_byte_count,
   input logic                           rsp_last
);
   import dss_pkg::*;

   // A stalled result stays presented with all of its fields unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value)
         && $stable(rsp_segment_number) && $stable(rsp_byte_count) && $stable(rsp_last))
      else $error("stalled result changed");

   // Reset drops any pending result.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An error and a stream end always close the request that caused them.
   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR || rsp_kind == KIND_STREAM_END) |-> rsp_last)
      else $error("error or stream end not marked last");

   // Only a segment end carries a byte count.
   a_count_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SEGMENT_END |-> rsp_byte_count == '0)
      else $error("byte count on a result that is not a segment end");

   // A segment end that closes a stream is followed by the stream end.
   a_end_then_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_SEGMENT_END && !rsp_last
         |=> !rsp_valid || rsp_kind == KIND_STREAM_END)
      else $error("segment end at stream end not followed by stream end");

endmodule

bind delimiter_stream_splitter dss_checker u_dss_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Delimiter stream splitter testbench
// Sends byte and end-mark transactions into the splitter and predicts every
// result with a behavioral model of the name phase, the delimiter matcher
// and the segment counters. Results are checked in order, field by field,
// while the sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
   import dss_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_HELD     = DEF_MAX_DELIM_LEN;

   typedef enum logic {PHASE_NAMING, PHASE_CONTENT} split_phase_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] value;
      logic [SEG_W-1:0]  segment;
      logic [31:0]       count;
      logic              last;
   } split_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   req_end_of_input = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   kind_type               rsp_kind;
   logic [BYTE_W-1:0]      rsp_value;
   logic [SEG_W-1:0]       rsp_segment_number;
   logic [CNT_OUT_W-1:0]   rsp_byte_count;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_DELIM_WORD;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int send_idle_pct = 10;
   int stall_pct     = 73;
   int error_count   = 0;
   int quiet_cycles  = 0;

   // Behavioral copy of the configuration and the splitter state.
   logic [63:0]       delim_word_m;
   logic [3:0]        delim_len_m;
   logic [SEG_W-1:0]  select_m;
   split_phase_type   phase_m;
   logic [3:0]        held_count;
   logic [SEG_W-1:0]  segment_index_m;
   logic [31:0]       segment_bytes_m;

   split_result_type due_results[$];
   split_result_type item_results[$];

   delimiter_stream_splitter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_value          (rsp_value),
      .rsp_segment_number (rsp_segment_number),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] delimiter_byte(input logic [3:0] pos);
      return delim_word_m[pos[2:0]*8 +: 8];
   endfunction

   function automatic int unsigned delimiter_span();
      if (delim_len_m == 0) return 1;
      if (delim_len_m > MAX_HELD) return MAX_HELD;
      return delim_len_m;
   endfunction

   function automatic bit segment_selected();
      return select_m == 0 || select_m == segment_index_m;
   endfunction

   function automatic void add_content(input int unsigned n);
      logic [32:0] sum;
      sum = {1'b0, segment_bytes_m} + n;
      segment_bytes_m = sum[32] ? '1 : sum[31:0];
   endfunction

   function automatic void clear_split_state();
      phase_m = PHASE_NAMING;
      held_count = '0;
      segment_index_m = '0;
      segment_bytes_m = '0;
   endfunction

   function automatic void note_result(input kind_type k, input logic [7:0] v,
                                       input logic [SEG_W-1:0] s, input logic [31:0] c);
      split_result_type r;
      r.kind = k;
      r.value = v;
      r.segment = s;
      r.count = c;
      r.last = 1'b0;
      item_results.push_back(r);
   endfunction

   // Held delimiter bytes are rebuilt from the current delimiter word.
   function automatic void release_held();
      if (segment_selected())
         for (int i = 0; i < held_count; i++)
            note_result(KIND_CONTENT, delimiter_byte(i[3:0]), segment_index_m, '0);
      add_content(held_count);
      held_count = '0;
   endfunction

   function automatic void split_byte(input logic [7:0] b, input logic eoi);
      item_results.delete();
      if (phase_m == PHASE_NAMING) begin
         if (eoi) begin
            note_result(KIND_ERROR, '0, segment_index_m, '0);
            clear_split_state();
         end else if (b == NEWLINE_BYTE) begin
            if (segment_index_m != '1) segment_index_m++;
            segment_bytes_m = '0;
            held_count = '0;
            phase_m = PHASE_CONTENT;
         end else begin
            note_result(KIND_NAME, b,
                        (segment_index_m == '1) ? segment_index_m : segment_index_m + 16'd1,
                        '0);
         end
      end else if (eoi) begin
         release_held();
         note_result(KIND_SEGMENT_END, '0, segment_index_m, segment_bytes_m);
         note_result(KIND_STREAM_END, '0, segment_index_m, '0);
         clear_split_state();
      end else if (held_count >= MAX_HELD || b != delimiter_byte(held_count)) begin
         // A broken match is never retried as the start of a new one.
         release_held();
         if (segment_selected()) note_result(KIND_CONTENT, b, segment_index_m, '0);
         add_content(1);
      end else begin
         held_count++;
         if (held_count >= delimiter_span()) begin
            note_result(KIND_SEGMENT_END, '0, segment_index_m, segment_bytes_m);
            held_count = '0;
            phase_m = PHASE_NAMING;
         end
      end
      if (item_results.size() > 0) item_results[item_results.size()-1].last = 1'b1;
      foreach (item_results[i]) due_results.push_back(item_results[i]);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      split_byte(b, eoi);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [63:0] word, input logic [3:0] len,
                                  input logic [SEG_W-1:0] sel);
      csr_index_type reg_index [3];
      logic [63:0]   reg_value [3];
      reg_index = '{CSR_DELIM_WORD, CSR_DELIM_LEN, CSR_SELECT};
      reg_value = '{word, {60'd0, len}, {48'd0, sel}};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_index[i];
         csr_data <= reg_value[i];
         do @(posedge clock); while (!csr_ready);
         case (reg_index[i])
            CSR_DELIM_WORD: delim_word_m = reg_value[i];
            CSR_DELIM_LEN:  delim_len_m = reg_value[i][3:0];
            CSR_SELECT:     select_m = reg_value[i][SEG_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Error in name phase, extreme bytes, a broken match without retry, a full
   // match and an end mark that flushes a held byte.
   task automatic test_framing();
      wait_for_drain();
      write_registers(64'h6261, 4'd2, 16'd0);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h6E, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'hFF, 1'b1);
   endtask

   // A length of zero acts as one and lengths above the maximum act as the
   // maximum; also the all-zero and all-one delimiter words.
   task automatic test_length_limits();
      wait_for_drain();
      write_registers(64'h0, 4'd0, 16'd0);
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h00, 1'b0);
      wait_for_drain();
      write_registers('1, 4'd15, 16'hFFFF);
      send_item(NEWLINE_BYTE, 1'b0);
      repeat (8) send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   // The held prefix is only a count, so a new delimiter word or length takes
   // effect on bytes that are already held.
   task automatic test_prefix_rewrite();
      wait_for_drain();
      write_registers(64'h636261, 4'd3, 16'd0);
      send_item(NEWLINE_BYTE, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      wait_for_drain();
      write_registers(64'h7A7978, 4'd3, 16'd0);
      send_item(8'h71, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(8'h79, 1'b0);
      wait_for_drain();
      write_registers(64'h7A7978, 4'd1, 16'd0);
      send_item(8'h7A, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   // Mostly well-formed segments: names, newlines and content that follows
   // the delimiter often enough to reach partial and full matches.
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [SEG_W-1:0] sel, input int item_total);
      logic [7:0]  b;
      logic        eoi;
      int unsigned roll;
      wait_for_drain();
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      write_registers({$urandom, $urandom}, 4'($urandom_range(15)), sel);
      for (int n = 0; n < item_total; n++) begin
         roll = $urandom_range(99);
         b = 8'($urandom_range(255));
         eoi = roll < 3;
         if (phase_m == PHASE_NAMING) begin
            if (roll >= 3 && roll < 30) b = NEWLINE_BYTE;
         end else if (roll >= 28 && held_count < MAX_HELD) begin
            b = delimiter_byte(held_count);
         end
         send_item(b, eoi);
      end
   endtask

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      split_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("result with nothing expected: kind %0d value 0x%0h", rsp_kind, rsp_value);
            error_count++;
         end else begin
            want = due_results.pop_front();
            compare_field("kind", want.kind, rsp_kind);
            compare_field("value", want.value, rsp_value);
            compare_field("segment_number", want.segment, rsp_segment_number);
            compare_field("byte_count", want.count, rsp_byte_count);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   // Any transaction on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("delimiter_stream_splitter verification failed");
         $finish;
      end
   end

   initial begin
      delim_word_m = '0;
      delim_len_m = 4'd1;
      select_m = '0;
      clear_split_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_framing();
      test_length_limits();
      test_prefix_rewrite();
      test_random_traffic(10, 73, 16'd0, 32);
      test_random_traffic(73, 10, 16'd2, 32);
      test_random_traffic(0, 0, 16'($urandom_range(1, 3)), 32);
      wait_for_drain();
      if (error_count == 0)
         $display("delimiter_stream_splitter verification clean");
      else
         $display("delimiter_stream_splitter verification failed");
      $finish;
   end

endmodule
